>>> hw/rtl/sds_pkg.sv
// ----------------------------------------------------------------------------
// sds_pkg
// Shared constants and types of the SCAN disk scheduler.
// ----------------------------------------------------------------------------
package sds_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int CYL_BITS    = 16;
    localparam int TOT_W       = 17;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_RUN = 1'b1;

    // result of the shared compare / distance unit
    typedef struct packed {
        logic                a_lt_b;
        logic                a_gt_b;
        logic [CYL_BITS-1:0] diff;
    } alu_res_t;

    // one head move as handed to the output register
    typedef struct packed {
        logic [CYL_BITS-1:0] from_cylinder;
        logic [CYL_BITS-1:0] to_cylinder;
        logic [CYL_BITS-1:0] distance;
        logic [TOT_W-1:0]    total_seek;
        logic [CNT_W-1:0]    request_count;
        logic                is_last;
    } move_t;

endpackage

>>> hw/rtl/sds_alu.sv
// ----------------------------------------------------------------------------
// sds_alu
// Shared compare and absolute-difference unit used by the insertion, search and sweep steps.
// ----------------------------------------------------------------------------
module sds_alu
    import sds_pkg::*;
(
    input  logic [CYL_BITS-1:0] a,
    input  logic [CYL_BITS-1:0] b,
    output alu_res_t            res
);

    logic [CYL_BITS:0] sub_ab;

    // one subtractor gives the ordering, and the distance when a is not below b
    assign sub_ab     = {1'b0, a} - {1'b0, b};
    assign res.a_lt_b = sub_ab[CYL_BITS];
    assign res.a_gt_b = !sub_ab[CYL_BITS] && (sub_ab[CYL_BITS-1:0] != '0);
    assign res.diff   = sub_ab[CYL_BITS] ? (b - a) : sub_ab[CYL_BITS-1:0];

endmodule

>>> hw/rtl/sds_seq.sv
// ----------------------------------------------------------------------------
// sds_seq
// Request store and sequencer: sorted insertion and the SCAN sweep through the
// shared compare / distance unit, one entry per cycle unless out_free is low.
// ----------------------------------------------------------------------------
module sds_seq
    import sds_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic [CYL_BITS-1:0] s_cylinder,
    input  logic [CYL_BITS-1:0] last_cylinder,
    input  logic                out_free,
    output logic                move_valid,
    output move_t               move
);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_INS_CMP = 8'b0000_0010,
        ST_INS_PUT = 8'b0000_0100,
        ST_SRCH    = 8'b0000_1000,
        ST_UP      = 8'b0001_0000,
        ST_TURN    = 8'b0010_0000,
        ST_DOWN    = 8'b0100_0000,
        ST_EMPTY   = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    first_reg, first_next;
    logic [CYL_BITS-1:0] pos_reg, pos_next;
    logic [TOT_W-1:0]    total_reg, total_next;

    logic [CYL_BITS-1:0] mem [QUEUE_DEPTH];
    logic [CYL_BITS-1:0] rdata_reg;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [CYL_BITS-1:0] mem_wdata;
    logic [IDX_W-1:0]    mem_raddr;

    logic [CYL_BITS-1:0] alu_a;
    alu_res_t            alu_res;
    logic [TOT_W-1:0]    total_sum;
    logic [CNT_W-1:0]    count_m1, idx_p1, idx_m1, idx_m2, first_m1;

    sds_alu u_alu (
        .a   (alu_a),
        .b   (pos_reg),
        .res (alu_res)
    );

    assign count_m1  = count_reg - CNT_W'(1);
    assign idx_p1    = idx_reg + CNT_W'(1);
    assign idx_m1    = idx_reg - CNT_W'(1);
    assign idx_m2    = idx_reg - CNT_W'(2);
    assign first_m1  = first_reg - CNT_W'(1);
    assign total_sum = total_reg + TOT_W'(alu_res.diff);
    assign alu_a     = (state_reg == ST_TURN) ? last_cylinder : rdata_reg;
    assign s_ready   = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        first_next = first_reg;
        pos_next   = pos_reg;
        total_next = total_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg[IDX_W-1:0];
        mem_wdata  = pos_reg;
        mem_raddr  = idx_reg[IDX_W-1:0];
        move_valid = 1'b0;
        move.from_cylinder = pos_reg;
        move.to_cylinder   = alu_a;
        move.distance      = alu_res.diff;
        move.total_seek    = total_sum;
        move.request_count = count_reg;
        move.is_last       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                mem_raddr = (s_kind == KIND_RUN) ? '0 : count_m1[IDX_W-1:0];
                if (s_valid) begin
                    pos_next   = s_cylinder;
                    total_next = '0;
                    if (s_kind == KIND_ADD) begin
                        if (count_reg < CNT_W'(QUEUE_DEPTH)) begin
                            if (count_reg == '0) begin
                                mem_we     = 1'b1;
                                mem_waddr  = '0;
                                mem_wdata  = s_cylinder;
                                count_next = CNT_W'(1);
                            end else begin
                                idx_next   = count_reg;
                                state_next = ST_INS_CMP;
                            end
                        end
                    end else if (count_reg == '0) begin
                        state_next = ST_EMPTY;
                    end else begin
                        idx_next   = '0;
                        state_next = ST_SRCH;
                    end
                end
            end
            ST_INS_CMP: begin
                // rdata is the entry just below the hole at idx
                mem_we = 1'b1;
                if (alu_res.a_gt_b) begin
                    mem_wdata = rdata_reg;
                    idx_next  = idx_m1;
                    if (idx_reg == CNT_W'(1)) begin
                        state_next = ST_INS_PUT;
                    end else begin
                        mem_raddr = idx_m2[IDX_W-1:0];
                    end
                end else begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_INS_PUT: begin
                mem_we     = 1'b1;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_IDLE;
            end
            ST_SRCH: begin
                if (!alu_res.a_lt_b) begin
                    first_next = idx_reg;
                    state_next = ST_UP;
                end else if (idx_p1 == count_reg) begin
                    first_next = count_reg;
                    state_next = ST_TURN;
                end else begin
                    idx_next  = idx_p1;
                    mem_raddr = idx_p1[IDX_W-1:0];
                end
            end
            ST_UP: begin
                if (out_free) begin
                    move_valid = 1'b1;
                    pos_next   = rdata_reg;
                    total_next = total_sum;
                    if (idx_p1 == count_reg) begin
                        if (first_reg == '0) begin
                            move.is_last = 1'b1;
                            count_next   = '0;
                            state_next   = ST_IDLE;
                        end else begin
                            state_next = ST_TURN;
                        end
                    end else begin
                        idx_next  = idx_p1;
                        mem_raddr = idx_p1[IDX_W-1:0];
                    end
                end
            end
            ST_TURN: begin
                // trip to the far end, prefetching the highest lower request
                mem_raddr = first_m1[IDX_W-1:0];
                if (out_free) begin
                    move_valid = 1'b1;
                    pos_next   = last_cylinder;
                    total_next = total_sum;
                    idx_next   = first_m1;
                    state_next = ST_DOWN;
                end
            end
            ST_DOWN: begin
                if (out_free) begin
                    move_valid = 1'b1;
                    pos_next   = rdata_reg;
                    total_next = total_sum;
                    if (idx_reg == '0) begin
                        move.is_last = 1'b1;
                        count_next   = '0;
                        state_next   = ST_IDLE;
                    end else begin
                        idx_next  = idx_m1;
                        mem_raddr = idx_m1[IDX_W-1:0];
                    end
                end
            end
            ST_EMPTY: begin
                move.to_cylinder   = pos_reg;
                move.distance      = '0;
                move.total_seek    = '0;
                move.request_count = '0;
                move.is_last       = 1'b1;
                if (out_free) begin
                    move_valid = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        idx_reg   <= idx_next;
        first_reg <= first_next;
        pos_reg   <= pos_next;
        total_reg <= total_next;
    end

endmodule

>>> hw/rtl/scan_disk_scheduler_top.sv
// ----------------------------------------------------------------------------
// scan_disk_scheduler_top
// SCAN (elevator) disk scheduler with a sorted request queue, upward sweep
// first, and a registered move output.
// ----------------------------------------------------------------------------
// An add beat (kind 0) inserts a cylinder into a queue of up to QUEUE_DEPTH
// requests kept in ascending order; a full queue ignores it. Insertion shifts
// larger entries up one store entry per cycle. A run beat (kind 1) carries
// the head position: the sequencer searches the store for the first request
// at or above the head (one entry per cycle), then emits one move per cycle
// upward while the output takes them, one trip to last_cylinder if lower
// requests remain, and the lower requests descending; an empty queue gives
// one zero move. The pace of insertion and run is set by the single read port
// of the request store and the one shared compare / distance unit. Input
// ready is high only while the sequencer is idle; the output register lets
// the next beat be taken while the final move still waits. last_cylinder is
// written through cfg_wr_en / cfg_wr_data and resets to the top cylinder.
module scan_disk_scheduler_top
    import sds_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CYL_BITS-1:0] cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic [CYL_BITS-1:0] s_cylinder,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CYL_BITS-1:0] m_from_cylinder,
    output logic [CYL_BITS-1:0] m_to_cylinder,
    output logic [CYL_BITS-1:0] m_distance,
    output logic [TOT_W-1:0]    m_total_seek,
    output logic [CNT_W-1:0]    m_request_count,
    output logic                m_is_last
);

    logic [CYL_BITS-1:0] last_cylinder_reg;
    logic                m_valid_reg;
    move_t               move_reg;
    logic                out_free;
    logic                move_valid;
    move_t               move;

    assign out_free = !m_valid_reg || m_ready;

    sds_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_cylinder    (s_cylinder),
        .last_cylinder (last_cylinder_reg),
        .out_free      (out_free),
        .move_valid    (move_valid),
        .move          (move)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_cylinder_reg <= '1;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                last_cylinder_reg <= cfg_wr_data;
            end
            if (out_free) begin
                m_valid_reg <= move_valid;
            end
        end
        if (out_free && move_valid) begin
            move_reg <= move;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_from_cylinder = move_reg.from_cylinder;
    assign m_to_cylinder   = move_reg.to_cylinder;
    assign m_distance      = move_reg.distance;
    assign m_total_seek    = move_reg.total_seek;
    assign m_request_count = move_reg.request_count;
    assign m_is_last       = move_reg.is_last;

endmodule

>>> hw/rtl/sds_checker.sv
// ----------------------------------------------------------------------------
// sds_checker
// Port-level checks on the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module sds_checker
    import sds_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                cfg_wr_en,
    input logic [CYL_BITS-1:0] cfg_wr_data,
    input logic                s_valid,
    input logic                s_ready,
    input logic                s_kind,
    input logic [CYL_BITS-1:0] s_cylinder,
    input logic                m_valid,
    input logic                m_ready,
    input logic [CYL_BITS-1:0] m_from_cylinder,
    input logic [CYL_BITS-1:0] m_to_cylinder,
    input logic [CYL_BITS-1:0] m_distance,
    input logic [TOT_W-1:0]    m_total_seek,
    input logic [CNT_W-1:0]    m_request_count,
    input logic                m_is_last
);

    // a stalled move beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_to_cylinder)
            && $stable(m_total_seek) && $stable(m_is_last))
        else $error("stalled move beat changed");

    // a run beat keeps the input side busy while the sweep works
    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_kind == KIND_RUN) |=> !s_ready)
        else $error("input ready after run beat");

    // the distance always matches the two end points
    a_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_distance == ((m_to_cylinder >= m_from_cylinder)
            ? (m_to_cylinder - m_from_cylinder) : (m_from_cylinder - m_to_cylinder)))
        else $error("move distance wrong");

    // empty queue run: one zero move that closes the run
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_request_count == '0) |-> m_is_last && (m_total_seek == '0)
            && (m_from_cylinder == m_to_cylinder))
        else $error("empty run move wrong");

    // reset drops the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("move valid after reset");

endmodule

bind scan_disk_scheduler_top sds_checker u_sds_checker (.*);

>>> tb/sv/tb_scan_disk_scheduler_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scan_disk_scheduler_top
// Self-checking bench for the SCAN disk scheduler. A short directed table of
// adds, runs and last_cylinder writes is followed by random request bursts
// under several turn-back settings. Every move beat is compared field by
// field against an elevator model kept inside the bench, while both
// handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_scan_disk_scheduler_top;
    import sds_pkg::*;

    localparam int                  CYCLE_LIMIT  = 400000;
    localparam int                  QUIET_CYCLES = 48;
    localparam int                  PHASE_BEATS  = 30;
    localparam logic [CYL_BITS-1:0] TOP_CYL      = '1;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_op_t;

    typedef struct {
        row_op_t             op;
        logic                kind;
        logic [CYL_BITS-1:0] cyl;
        logic                typed;
        move_t               want;
    } row_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [CYL_BITS-1:0] cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic                s_kind;
    logic [CYL_BITS-1:0] s_cylinder;
    logic                m_valid;
    logic                m_ready;
    logic [CYL_BITS-1:0] m_from_cylinder;
    logic [CYL_BITS-1:0] m_to_cylinder;
    logic [CYL_BITS-1:0] m_distance;
    logic [TOT_W-1:0]    m_total_seek;
    logic [CNT_W-1:0]    m_request_count;
    logic                m_is_last;

    // elevator model state
    logic [CYL_BITS-1:0] queue_cyl [QUEUE_DEPTH];
    int                  queue_len;
    logic [CYL_BITS-1:0] turn_cyl;
    logic [TOT_W-1:0]    seek_sum;
    move_t               sweep_plan [$];
    move_t               pending_moves [$];
    row_t                dir_tab [$];

    logic                calm = 1'b0;
    logic [CYL_BITS-1:0] recent_cyl = '0;
    int                  hold;
    int                  err_cnt  = 0;
    int                  beat_cnt = 0;
    int                  run_cnt  = 0;
    int                  move_cnt = 0;
    int                  cfg_cnt  = 0;
    int unsigned         cycle_cnt = 0;

    scan_disk_scheduler_top i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_cylinder      (s_cylinder),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_from_cylinder (m_from_cylinder),
        .m_to_cylinder   (m_to_cylinder),
        .m_distance      (m_distance),
        .m_total_seek    (m_total_seek),
        .m_request_count (m_request_count),
        .m_is_last       (m_is_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // a move that leaves the head where it is and closes the run
    function automatic move_t still_move(input logic [CYL_BITS-1:0] head, input int cnt);
        move_t m;
        m.from_cylinder = head;
        m.to_cylinder   = head;
        m.distance      = '0;
        m.total_seek    = '0;
        m.request_count = CNT_W'(cnt);
        m.is_last       = 1'b1;
        return m;
    endfunction

    function automatic void log_move(input logic [CYL_BITS-1:0] from_c,
                                     input logic [CYL_BITS-1:0] to_c);
        move_t m;
        m.from_cylinder = from_c;
        m.to_cylinder   = to_c;
        m.distance      = (from_c > to_c) ? from_c - to_c : to_c - from_c;
        seek_sum        = seek_sum + TOT_W'(m.distance);
        m.total_seek    = seek_sum;
        m.request_count = CNT_W'(queue_len);
        m.is_last       = 1'b0;
        sweep_plan.push_back(m);
    endfunction

    // updates the model for one beat and leaves its moves in sweep_plan
    function automatic void plan_beat(input logic kind, input logic [CYL_BITS-1:0] cyl);
        int                  i;
        int                  j;
        int                  first;
        logic [CYL_BITS-1:0] pos;
        move_t               m;
        sweep_plan.delete();
        if (kind == KIND_ADD) begin
            if (queue_len < QUEUE_DEPTH) begin
                j = queue_len;
                while (j > 0 && queue_cyl[j-1] > cyl) begin
                    queue_cyl[j] = queue_cyl[j-1];
                    j--;
                end
                queue_cyl[j] = cyl;
                queue_len++;
            end
        end else begin
            pos      = cyl;
            seek_sum = '0;
            first    = queue_len;
            for (i = queue_len - 1; i >= 0; i--) begin
                if (queue_cyl[i] >= cyl) begin
                    first = i;
                end
            end
            for (i = first; i < queue_len; i++) begin
                log_move(pos, queue_cyl[i]);
                pos = queue_cyl[i];
            end
            // lower requests left: out to the turn-back cylinder, then down
            if (first > 0) begin
                log_move(pos, turn_cyl);
                pos = turn_cyl;
                for (i = first - 1; i >= 0; i--) begin
                    log_move(pos, queue_cyl[i]);
                    pos = queue_cyl[i];
                end
            end
            if (sweep_plan.size() == 0) begin
                sweep_plan.push_back(still_move(cyl, 0));
            end
            m = sweep_plan.pop_back();
            m.is_last = 1'b1;
            sweep_plan.push_back(m);
            queue_len = 0;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 19);
        if (r < 11) begin
            return 0;
        end
        if (r < 18) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [CYL_BITS-1:0] pick_cyl();
        case ($urandom_range(0, 9))
            0: begin
                return '0;
            end
            1: begin
                return TOP_CYL;
            end
            2: begin
                return recent_cyl;
            end
            3: begin
                return CYL_BITS'(turn_cyl + $urandom_range(0, 8) - 4);
            end
            4: begin
                if (queue_len > 0) begin
                    return queue_cyl[$urandom_range(0, queue_len - 1)];
                end
            end
            default: ;
        endcase
        return CYL_BITS'($urandom);
    endfunction

    task automatic send_beat(input logic kind, input logic [CYL_BITS-1:0] cyl,
                             input logic typed, input move_t want);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_kind     = kind;
        s_cylinder = cyl;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // adds into a full queue are dropped by the block
        if (kind == KIND_RUN || queue_len < QUEUE_DEPTH) begin
            beat_cnt++;
        end
        if (kind == KIND_RUN) begin
            run_cnt++;
        end
        plan_beat(kind, cyl);
        if (typed) begin
            pending_moves.push_back(want);
        end else begin
            foreach (sweep_plan[k]) pending_moves.push_back(sweep_plan[k]);
        end
        recent_cyl = cyl;
    endtask

    task automatic write_turn(input logic [CYL_BITS-1:0] val);
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_moves.size() != 0) @(posedge aclk);
        // an add beat gives no move, so let a late insert settle first
        repeat (QUIET_CYCLES) @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        turn_cyl  = val;
        cfg_cnt++;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge aclk) begin : move_check
        move_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            move_cnt++;
            if (pending_moves.size() == 0) begin
                $error("move beat %0d -> %0d with nothing expected",
                       m_from_cylinder, m_to_cylinder);
                err_cnt++;
            end else begin
                want = pending_moves.pop_front();
                check_field("from_cylinder", want.from_cylinder, m_from_cylinder);
                check_field("to_cylinder", want.to_cylinder, m_to_cylinder);
                check_field("distance", want.distance, m_distance);
                check_field("total_seek", want.total_seek, m_total_seek);
                check_field("request_count", want.request_count, m_request_count);
                check_field("is_last", want.is_last, m_is_last);
            end
        end
    end

    initial begin : result_stall
        m_ready = 1'b0;
        hold    = 0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_ready = 1'b0;
                hold--;
            end else begin
                m_ready = 1'b1;
                hold    = pick_gap();
            end
        end
    end

    initial begin : watchdog
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        logic [CYL_BITS-1:0] phase_turn [4];
        int                  sent;
        int                  n_add;
        logic                big_done;
        aclk        = 1'b0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_kind      = KIND_ADD;
        s_cylinder  = '0;
        foreach (queue_cyl[i]) queue_cyl[i] = '0;
        queue_len = 0;
        turn_cyl  = TOP_CYL;
        seek_sum  = '0;

        // empty queue at both ends of the disk
        dir_tab.push_back('{ROW_BEAT, KIND_RUN, 16'd0, 1'b1, still_move(16'd0, 0)});
        dir_tab.push_back('{ROW_BEAT, KIND_RUN, TOP_CYL, 1'b1, still_move(TOP_CYL, 0)});
        // duplicates, a request on the head and lower ones left for the way back
        dir_tab.push_back('{ROW_BEAT, KIND_ADD, 16'd100, 1'b0, '0});
        dir_tab.push_back('{ROW_BEAT, KIND_ADD, 16'd50, 1'b0, '0});
        dir_tab.push_back('{ROW_BEAT, KIND_ADD, 16'd100, 1'b0, '0});
        dir_tab.push_back('{ROW_BEAT, KIND_ADD, 16'd0, 1'b0, '0});
        dir_tab.push_back('{ROW_BEAT, KIND_ADD, TOP_CYL, 1'b0, '0});
        dir_tab.push_back('{ROW_BEAT, KIND_RUN, 16'd100, 1'b0, '0});
        // nothing below the head, so no trip to the end
        dir_tab.push_back('{ROW_BEAT, KIND_ADD, 16'd600, 1'b0, '0});
        dir_tab.push_back('{ROW_BEAT, KIND_ADD, 16'd500, 1'b0, '0});
        dir_tab.push_back('{ROW_BEAT, KIND_RUN, 16'd0, 1'b0, '0});
        // nothing above the head
        dir_tab.push_back('{ROW_BEAT, KIND_ADD, 16'd20, 1'b0, '0});
        dir_tab.push_back('{ROW_BEAT, KIND_ADD, 16'd10, 1'b0, '0});
        dir_tab.push_back('{ROW_BEAT, KIND_RUN, TOP_CYL, 1'b0, '0});
        dir_tab.push_back('{ROW_BEAT, KIND_ADD, 16'd7, 1'b0, '0});
        dir_tab.push_back('{ROW_BEAT, KIND_RUN, 16'd7, 1'b1, still_move(16'd7, 1)});
        // turn-back at cylinder 0 below the head; the seek total goes past 16 bits
        dir_tab.push_back('{ROW_CFG, KIND_ADD, 16'd0, 1'b0, '0});
        dir_tab.push_back('{ROW_BEAT, KIND_ADD, 16'd0, 1'b0, '0});
        dir_tab.push_back('{ROW_BEAT, KIND_ADD, 16'd65534, 1'b0, '0});
        dir_tab.push_back('{ROW_BEAT, KIND_RUN, TOP_CYL, 1'b0, '0});
        dir_tab.push_back('{ROW_BEAT, KIND_ADD, 16'd40000, 1'b0, '0});
        dir_tab.push_back('{ROW_BEAT, KIND_ADD, 16'd30000, 1'b0, '0});
        dir_tab.push_back('{ROW_BEAT, KIND_RUN, 16'd35000, 1'b0, '0});

        phase_turn[0] = CYL_BITS'($urandom);
        phase_turn[1] = TOP_CYL;
        phase_turn[2] = '0;
        phase_turn[3] = CYL_BITS'($urandom_range(1, 255));

        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_tab[r]) begin
            if (dir_tab[r].op == ROW_CFG) begin
                write_turn(dir_tab[r].cyl);
            end else begin
                send_beat(dir_tab[r].kind, dir_tab[r].cyl, dir_tab[r].typed, dir_tab[r].want);
            end
        end

        big_done = 1'b0;
        for (int p = 0; p < 4; p++) begin
            write_turn(phase_turn[p]);
            sent = 0;
            while (sent < PHASE_BEATS) begin
                calm = ($urandom_range(0, 4) == 0);
                // overfill once for sure, and now and then after that
                if (p == 1 && !big_done) begin
                    n_add    = QUEUE_DEPTH + 3;
                    big_done = 1'b1;
                end else if ($urandom_range(0, 19) == 0) begin
                    n_add = $urandom_range(QUEUE_DEPTH - 2, QUEUE_DEPTH + 3);
                end else begin
                    n_add = $urandom_range(0, 6);
                end
                repeat (n_add) send_beat(KIND_ADD, pick_cyl(), 1'b0, '0);
                send_beat(KIND_RUN, pick_cyl(), 1'b0, '0);
                sent += n_add + 1;
            end
        end
        calm = 1'b0;

        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_moves.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);

        $display("covered %0d beats in %0d schedule runs over %0d last_cylinder settings",
                 beat_cnt, run_cnt, cfg_cnt + 1);
        $display("compared %0d move beats, %0d mismatches", move_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/sds_pkg.sv
hw/rtl/sds_alu.sv
hw/rtl/sds_seq.sv
hw/rtl/scan_disk_scheduler_top.sv
hw/rtl/sds_checker.sv
tb/sv/tb_scan_disk_scheduler_top.sv
